@@ hw/rtl/env_sensor_compensation_macros.svh @@
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication, sampled on aclk, off during reset
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/esc_pkg.sv @@
`timescale 1ns / 1ps

package esc_pkg;

    localparam int StateW = 5;

    // sequencer steps, in program order
    localparam logic [StateW-1:0] ST_IDLE = 5'd0;
    localparam logic [StateW-1:0] ST_T1   = 5'd1;
    localparam logic [StateW-1:0] ST_T2   = 5'd2;
    localparam logic [StateW-1:0] ST_T3   = 5'd3;
    localparam logic [StateW-1:0] ST_TFIN = 5'd4;
    localparam logic [StateW-1:0] ST_TOUT = 5'd5;
    localparam logic [StateW-1:0] ST_PV   = 5'd6;
    localparam logic [StateW-1:0] ST_P4   = 5'd7;
    localparam logic [StateW-1:0] ST_P5   = 5'd8;
    localparam logic [StateW-1:0] ST_P6   = 5'd9;
    localparam logic [StateW-1:0] ST_P7   = 5'd10;
    localparam logic [StateW-1:0] ST_P8   = 5'd11;
    localparam logic [StateW-1:0] ST_P9   = 5'd12;
    localparam logic [StateW-1:0] ST_PCHK = 5'd13;
    localparam logic [StateW-1:0] ST_P10  = 5'd14;
    localparam logic [StateW-1:0] ST_PDIV = 5'd15;
    localparam logic [StateW-1:0] ST_P11  = 5'd16;
    localparam logic [StateW-1:0] ST_P12  = 5'd17;
    localparam logic [StateW-1:0] ST_P13  = 5'd18;
    localparam logic [StateW-1:0] ST_PFIN = 5'd19;
    localparam logic [StateW-1:0] ST_POUT = 5'd20;
    localparam logic [StateW-1:0] ST_HV   = 5'd21;
    localparam logic [StateW-1:0] ST_H14  = 5'd22;
    localparam logic [StateW-1:0] ST_H15  = 5'd23;
    localparam logic [StateW-1:0] ST_H16  = 5'd24;
    localparam logic [StateW-1:0] ST_H17  = 5'd25;
    localparam logic [StateW-1:0] ST_H18  = 5'd26;
    localparam logic [StateW-1:0] ST_H19  = 5'd27;
    localparam logic [StateW-1:0] ST_H20  = 5'd28;
    localparam logic [StateW-1:0] ST_H21  = 5'd29;
    localparam logic [StateW-1:0] ST_HOUT = 5'd30;
    localparam logic [StateW-1:0] ST_EMIT = 5'd31;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] plo;
        logic [63:0] phi;
        logic [15:0] p9;
        logic [63:0] hum;
    } esc_cal_t;

    typedef struct packed {
        logic [StateW-1:0] uop;
        logic              load;
        logic              mul_go;
        logic              div_go;
        logic              wb;
        logic              emit;
    } esc_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic skip_temp;
        logic v1_zero;
        logic hum_off;
    } esc_status_t;

endpackage

@@ hw/rtl/env_sensor_compensation.sv @@
`timescale 1ns / 1ps

// channel       | direction | transaction contents
// --------------+-----------+--------------------------------------------------
// s_ (stream)   | in        | raw temperature, pressure, humidity
// m_ (stream)   | out       | compensated temperature, pressure, humidity + valids
// apb           | in/out    | calibration registers at byte address 8*i, 64-bit
//
// each transaction runs up to 21 multiplies through one shared 64x16 multiply-accumulate
// unit, four passes each, and at most one division through the bit-serial 64-bit divider;
// a skipped temperature bypasses the temperature steps; a zero divisor or humidity off skips later steps
// reset is synchronous, active low; fine temperature, calibration registers and valid flags clear to zero
// a new transaction is taken while the previous result waits in the output register

module env_sensor_compensation
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // raw_temperature[23:0], raw_pressure[47:24],
                                  // raw_humidity[63:48]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata   // temperature_centi[23:0], temperature_valid[24],
                                  // pressure_pa[48:25], pressure_valid[49],
                                  // humidity_q10[66:50], humidity_valid[67], zero[71:68]
);

    // register indexes on paddr[5:3]
    localparam logic [2:0] REG_TEMP = 3'd0;
    localparam logic [2:0] REG_PLO  = 3'd1;
    localparam logic [2:0] REG_PHI  = 3'd2;
    localparam logic [2:0] REG_P9   = 3'd3;
    localparam logic [2:0] REG_HUM  = 3'd4;

    esc_cal_t    cal_reg;
    esc_cmd_t    cmd;
    esc_status_t status;
    logic        cfg_wr;
    logic [23:0] temperature_centi, pressure_pa;
    logic [16:0] humidity_q10;
    logic        temperature_valid, pressure_valid, humidity_valid;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // calibration words; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_reg <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[5:3])
                REG_TEMP: cal_reg.temp <= pwdata[47:0];
                REG_PLO:  cal_reg.plo  <= pwdata;
                REG_PHI:  cal_reg.phi  <= pwdata;
                REG_P9:   cal_reg.p9   <= pwdata[15:0];
                REG_HUM:  cal_reg.hum  <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[5:3])
            REG_TEMP: prdata = {16'd0, cal_reg.temp};
            REG_PLO:  prdata = cal_reg.plo;
            REG_PHI:  prdata = cal_reg.phi;
            REG_P9:   prdata = {48'd0, cal_reg.p9};
            REG_HUM:  prdata = cal_reg.hum;
            default:  prdata = '0;
        endcase
    end

    // sequencer: one step per compensation operation
    esc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // working registers, shared multiplier and divider, output register
    esc_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cal               (cal_reg),
        .raw_temperature   (s_tdata[23:0]),
        .raw_pressure      (s_tdata[47:24]),
        .raw_humidity      (s_tdata[63:48]),
        .status            (status),
        .temperature_centi (temperature_centi),
        .temperature_valid (temperature_valid),
        .pressure_pa       (pressure_pa),
        .pressure_valid    (pressure_valid),
        .humidity_q10      (humidity_q10),
        .humidity_valid    (humidity_valid)
    );

    assign m_tdata = {4'd0, humidity_valid, humidity_q10, pressure_valid, pressure_pa,
                      temperature_valid, temperature_centi};

endmodule

@@ hw/rtl/esc_mul.sv @@
`timescale 1ns / 1ps

module esc_mul
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] p
);

    logic [63:0] a_reg, b_reg, acc_reg;
    logic [1:0]  cnt_reg;
    logic        busy_reg, done_reg;

    // one 64x16 partial product per cycle, low 64 bits kept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + a_reg * {48'd0, b_reg[15:0]};
            a_reg   <= {a_reg[47:0], 16'd0};
            b_reg   <= {16'd0, b_reg[63:16]};
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

@@ hw/rtl/esc_div.sv @@
`timescale 1ns / 1ps

module esc_div
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] q
);

    logic [64:0] rem_reg;
    logic [63:0] quo_reg, den_reg;
    logic        neg_reg, busy_reg, done_reg;
    logic [5:0]  cnt_reg;
    logic [64:0] rem_sh, trial;

    // restoring divide on magnitudes, one quotient bit per cycle
    assign rem_sh = {rem_reg[63:0], quo_reg[63]};
    assign trial  = rem_sh - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= a[63] ? 64'd0 - a : a;
            den_reg <= b[63] ? 64'd0 - b : b;
            neg_reg <= a[63] ^ b[63];
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? 64'd0 - quo_reg : quo_reg;

endmodule

@@ hw/rtl/esc_datapath.sv @@
`timescale 1ns / 1ps

module esc_datapath
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  esc_cmd_t    cmd,
    input  esc_cal_t    cal,
    input  logic [23:0] raw_temperature,
    input  logic [23:0] raw_pressure,
    input  logic [15:0] raw_humidity,
    output esc_status_t status,
    output logic [23:0] temperature_centi,
    output logic        temperature_valid,
    output logic [23:0] pressure_pa,
    output logic        pressure_valid,
    output logic [16:0] humidity_q10,
    output logic        humidity_valid
);

    function automatic logic signed [63:0] sx16(input logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic signed [63:0] ext32(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] x, input int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [23:0] sat24(input logic signed [63:0] x);
        if (x > 64'sd8388607) begin
            return 24'h7FFFFF;
        end else if (x < -64'sd8388608) begin
            return 24'h800000;
        end
        return x[23:0];
    endfunction

    logic [23:0] rt_reg, rp_reg;
    logic [15:0] rh_reg;
    logic [31:0] fine_reg;
    logic signed [63:0] ra_reg, rb_reg, rc_reg, rd_reg;
    logic [23:0] t_val_reg, p_val_reg, t_out_reg, p_out_reg;
    logic [16:0] h_val_reg, h_out_reg;
    logic t_ok_reg, p_ok_reg, h_ok_reg, t_vo_reg, p_vo_reg, h_vo_reg;

    logic [63:0] mul_a, mul_b, mul_p, div_q;
    logic        mul_done, div_done;
    logic signed [63:0] prod, f64, t_scaled, p_rnd;
    logic [31:0] p32, hx_pre, h_v;
    logic [63:0] p_shift;

    // calibration fields
    logic signed [63:0] t1, t2, t3, pc1, pc2, pc3, pc4, pc5, pc6, pc7, pc8, pc9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    assign t1  = {48'd0, cal.temp[15:0]};
    assign t2  = sx16(cal.temp[31:16]);
    assign t3  = sx16(cal.temp[47:32]);
    assign pc1 = {48'd0, cal.plo[15:0]};
    assign pc2 = sx16(cal.plo[31:16]);
    assign pc3 = sx16(cal.plo[47:32]);
    assign pc4 = sx16(cal.plo[63:48]);
    assign pc5 = sx16(cal.phi[15:0]);
    assign pc6 = sx16(cal.phi[31:16]);
    assign pc7 = sx16(cal.phi[47:32]);
    assign pc8 = sx16(cal.phi[63:48]);
    assign pc9 = sx16(cal.p9);
    assign h1  = {24'd0, cal.hum[7:0]};
    assign h2  = {{16{cal.hum[23]}}, cal.hum[23:8]};
    assign h3  = {24'd0, cal.hum[31:24]};
    assign h4  = {{20{cal.hum[43]}}, cal.hum[43:32]};
    assign h5  = {{20{cal.hum[55]}}, cal.hum[55:44]};
    assign h6  = {{24{cal.hum[63]}}, cal.hum[63:56]};

    assign prod = $signed(mul_p);
    assign p32  = mul_p[31:0];
    assign f64  = ext32(fine_reg);
    assign t_scaled = ((f64 <<< 2) + f64 + 64'sd128) >>> 8;
    assign p_rnd    = (rb_reg + (rb_reg[63] ? 64'sd255 : 64'sd0)) >>> 8;
    assign p_shift  = {23'd0, 21'(21'd1048576 - {1'b0, rp_reg[23:4]}), 20'd0} << 11;
    assign hx_pre   = {2'b00, rh_reg, 14'd0} - {h4[11:0], 20'd0} - p32 + 32'd16384;
    assign h_v      = ra_reg[31:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.uop)
            ST_T1: begin
                mul_a = {47'd0, rt_reg[23:7]} - {47'd0, t1[15:0], 1'b0};
                mul_b = t2;
            end
            ST_T2: begin
                mul_a = {48'd0, rt_reg[23:8]} - t1;
                mul_b = {48'd0, rt_reg[23:8]} - t1;
            end
            ST_T3:  begin mul_a = rb_reg; mul_b = t3; end
            ST_P4:  begin mul_a = ra_reg; mul_b = ra_reg; end
            ST_P5:  begin mul_a = rb_reg; mul_b = pc6; end
            ST_P6:  begin mul_a = ra_reg; mul_b = pc5; end
            ST_P7:  begin mul_a = rb_reg; mul_b = pc3; end
            ST_P8:  begin mul_a = ra_reg; mul_b = pc2; end
            ST_P9:  begin mul_a = rd_reg + 64'sh0000_8000_0000_0000; mul_b = pc1; end
            ST_P10: begin mul_a = p_shift - rc_reg; mul_b = 64'd3125; end
            ST_PDIV: begin mul_a = rb_reg; mul_b = ra_reg; end
            ST_P11: begin mul_a = pc9; mul_b = rb_reg >>> 13; end
            ST_P12: begin mul_a = rc_reg; mul_b = rb_reg >>> 13; end
            ST_P13: begin mul_a = pc8; mul_b = rb_reg; end
            ST_H14: begin mul_a = ext32(h5); mul_b = ra_reg; end
            ST_H15: begin mul_a = ra_reg; mul_b = ext32(h6); end
            ST_H16: begin mul_a = ra_reg; mul_b = ext32(h3); end
            ST_H17: begin mul_a = rc_reg; mul_b = rd_reg; end
            ST_H18: begin mul_a = rc_reg; mul_b = ext32(h2); end
            ST_H19: begin mul_a = rb_reg; mul_b = rd_reg; end
            ST_H20: begin
                mul_a = ext32(asr32(h_v, 15));
                mul_b = ext32(asr32(h_v, 15));
            end
            ST_H21: begin mul_a = rc_reg; mul_b = ext32(h1); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    esc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    esc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_go),
        .a       (mul_a),
        .b       (mul_b),
        .done    (div_done),
        .q       (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fine_reg <= '0;
            t_ok_reg <= 1'b0;
            p_ok_reg <= 1'b0;
            h_ok_reg <= 1'b0;
        end else if (cmd.load) begin
            t_ok_reg <= 1'b0;
            p_ok_reg <= 1'b0;
            h_ok_reg <= 1'b0;
        end else if (cmd.wb) begin
            unique case (cmd.uop)
                ST_TFIN: fine_reg <= 32'(ra_reg + rb_reg);
                ST_TOUT: t_ok_reg <= 1'b1;
                ST_POUT: p_ok_reg <= 1'b1;
                ST_HOUT: h_ok_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rt_reg    <= raw_temperature;
            rp_reg    <= raw_pressure;
            rh_reg    <= raw_humidity;
            t_val_reg <= '0;
            p_val_reg <= '0;
            h_val_reg <= '0;
        end else if (cmd.wb) begin
            unique case (cmd.uop)
                ST_T1:   ra_reg <= prod >>> 11;
                ST_T2:   rb_reg <= prod >>> 12;
                ST_T3:   rb_reg <= prod >>> 14;
                ST_TOUT: t_val_reg <= sat24(t_scaled);
                ST_PV:   ra_reg <= f64 - 64'sd128000;
                ST_P4:   rb_reg <= prod;
                ST_P5:   rc_reg <= prod;
                ST_P6:   rc_reg <= rc_reg + (prod <<< 17) + (pc4 <<< 35);
                ST_P7:   rd_reg <= prod >>> 8;
                ST_P8:   rd_reg <= rd_reg + (prod <<< 12);
                ST_P9:   ra_reg <= prod >>> 33;
                ST_P10:  rb_reg <= prod;
                ST_PDIV: rb_reg <= $signed(div_q);
                ST_P11:  rc_reg <= prod;
                ST_P12:  rc_reg <= prod >>> 25;
                ST_P13:  rd_reg <= prod >>> 19;
                ST_PFIN: rb_reg <= ((rb_reg + rc_reg + rd_reg) >>> 8) + (pc7 <<< 4);
                ST_POUT: p_val_reg <= sat24(p_rnd);
                ST_HV:   ra_reg <= ext32(fine_reg - 32'd76800);
                ST_H14:  rb_reg <= ext32(asr32(hx_pre, 15));
                ST_H15:  rc_reg <= ext32(asr32(p32, 10));
                ST_H16:  rd_reg <= ext32(asr32(p32, 11) + 32'd32768);
                ST_H17:  rc_reg <= ext32(asr32(p32, 10) + 32'd2097152);
                ST_H18:  rd_reg <= ext32(asr32(p32 + 32'd8192, 14));
                ST_H19:  ra_reg <= ext32(p32);
                ST_H20:  rc_reg <= ext32(asr32(p32, 7));
                ST_H21:  ra_reg <= ext32(h_v - asr32(p32, 4));
                ST_HOUT: begin
                    if (h_v[31]) begin
                        h_val_reg <= '0;
                    end else if (h_v > 32'd419430400) begin
                        h_val_reg <= 17'd102400;
                    end else begin
                        h_val_reg <= h_v[28:12];
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_vo_reg <= 1'b0;
            p_vo_reg <= 1'b0;
            h_vo_reg <= 1'b0;
        end else if (cmd.emit) begin
            t_vo_reg <= t_ok_reg;
            p_vo_reg <= p_ok_reg;
            h_vo_reg <= h_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            t_out_reg <= t_val_reg;
            p_out_reg <= p_val_reg;
            h_out_reg <= h_val_reg;
        end
    end

    assign status.mul_done  = mul_done;
    assign status.div_done  = div_done;
    assign status.skip_temp = (rt_reg == 24'h800000);
    assign status.v1_zero   = (ra_reg == 64'sd0);
    assign status.hum_off   = (rh_reg == 16'h8000);

    assign temperature_centi = t_out_reg;
    assign temperature_valid = t_vo_reg;
    assign pressure_pa       = p_out_reg;
    assign pressure_valid    = p_vo_reg;
    assign humidity_q10      = h_out_reg;
    assign humidity_valid    = h_vo_reg;

endmodule

@@ hw/rtl/esc_ctrl.sv @@
`timescale 1ns / 1ps

module esc_ctrl
    import esc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  esc_status_t status,
    output esc_cmd_t    cmd
);

    logic [StateW-1:0] state_reg, state_next;
    logic              wait_reg, wait_next;
    logic              m_valid_reg, m_valid_next;
    logic              is_mul;

    assign is_mul = (state_reg >= ST_T1 && state_reg <= ST_T3)
                 || (state_reg >= ST_P4 && state_reg <= ST_P9)
                 || (state_reg == ST_P10)
                 || (state_reg >= ST_P11 && state_reg <= ST_P13)
                 || (state_reg >= ST_H14 && state_reg <= ST_H21);

    always_comb begin
        cmd          = '0;
        cmd.uop      = state_reg;
        state_next   = state_reg;
        wait_next    = wait_reg;
        m_valid_next = m_valid_reg && !m_tready;
        priority if (state_reg == ST_IDLE) begin
            if (s_tvalid) begin
                cmd.load   = 1'b1;
                state_next = ST_T1;
            end
        end else if (state_reg == ST_EMIT) begin
            if (!m_valid_reg || m_tready) begin
                cmd.emit     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
        end else if (state_reg == ST_T1 && !wait_reg && status.skip_temp) begin
            state_next = ST_PV;
        end else if (state_reg == ST_PCHK) begin
            state_next = status.v1_zero ? ST_EMIT : ST_P10;
        end else if (is_mul || state_reg == ST_PDIV) begin
            if (!wait_reg) begin
                cmd.mul_go = is_mul;
                cmd.div_go = !is_mul;
                wait_next  = 1'b1;
            end else if (is_mul ? status.mul_done : status.div_done) begin
                cmd.wb     = 1'b1;
                wait_next  = 1'b0;
                state_next = state_reg + 5'd1;
            end
        end else begin
            cmd.wb = 1'b1;
            if (state_reg == ST_POUT && status.hum_off) begin
                state_next = ST_EMIT;
            end else begin
                state_next = state_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wait_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wait_reg    <= wait_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

@@ hw/rtl/esc_checker.sv @@
`timescale 1ns / 1ps
`include "env_sensor_compensation_macros.svh"

module esc_checker
    import esc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    `ESC_ASSERT_NXT(a_m_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `ESC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready held after accept")
    `ESC_ASSERT_IMP(a_hum_needs_press, m_tvalid && m_tdata[67], m_tdata[49], "humidity without pressure")
    `ESC_ASSERT_IMP(a_press_zero, m_tvalid && !m_tdata[49], m_tdata[48:25] == 24'd0 && m_tdata[66:50] == 17'd0, "invalid pressure not zero")

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import esc_pkg::*;

    // calibration register indexes, 64-bit registers at byte address 8*i
    localparam int REG_TEMP_CAL  = 0;
    localparam int REG_PRESS_LO  = 1;
    localparam int REG_PRESS_HI  = 2;
    localparam int REG_PRESS_P9  = 3;
    localparam int REG_HUM_CAL   = 4;

    localparam logic [23:0] SKIP_TEMP = 24'h800000;
    localparam logic [15:0] HUM_OFF   = 16'h8000;
    localparam int LIMIT_CYCLES = 3000000;
    localparam int N_RANDOM     = 1330;

    // calibration sets used by the directed table
    localparam int CAL_RESET   = 0;
    localparam int CAL_TYPICAL = 1;
    localparam int CAL_ONES    = 2;

    typedef struct packed {
        logic [23:0] temp_c;
        logic        temp_ok;
        logic [23:0] press;
        logic        press_ok;
        logic [16:0] hum;
        logic        hum_ok;
    } reading_t;

    typedef struct {
        int          cal;
        logic [23:0] rt;
        logic [23:0] rp;
        logic [15:0] rh;
        bit          known;
        reading_t    exp_r;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    env_sensor_compensation uut (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow of the calibration registers and the fine temperature
    logic [63:0] cal_temp, cal_plo, cal_phi, cal_p9, cal_hum;
    logic [31:0] fine_t;

    reading_t readings_due[$];   // expected results in order
    bit       typed_known[$];    // per sent transaction: expectation typed in the table
    reading_t typed_value[$];
    int       errors = 0;
    int       cycles = 0;
    bit       long_hold = 1'b0;

    function automatic logic [63:0] sext(logic [63:0] v, int w);
        logic [63:0] sgn;
        sgn = 64'd1 << (w - 1);
        v = v & ((sgn << 1) - 64'd1);
        return (v ^ sgn) - sgn;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [31:0] asr32(logic [31:0] x, int s);
        return $signed(x) >>> s;
    endfunction

    function automatic logic [63:0] div_toward_zero(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [23:0] sat24(logic [63:0] x);
        if ($signed(x) > 64'sd8388607) return 24'h7FFFFF;
        if ($signed(x) < -64'sd8388608) return 24'h800000;
        return x[23:0];
    endfunction

    // compensation of one transaction; updates the fine temperature
    function automatic reading_t compensate(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh);
        reading_t r;
        logic [63:0] adc, t1, t2, t3, d1, d2, fine, v1, v2, p, a, b;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, q;
        r = '0;
        if (rt != SKIP_TEMP) begin
            adc = 64'(rt) >> 4;
            t1 = cal_temp & 64'hFFFF;
            t2 = sext(cal_temp >> 16, 16);
            t3 = sext(cal_temp >> 32, 16);
            d1 = (adc >> 3) - (t1 << 1);
            d2 = (adc >> 4) - t1;
            v1 = asr64(d1 * t2, 11);
            v2 = asr64(asr64(d2 * d2, 12) * t3, 14);
            fine_t = 32'(v1 + v2);
            r.temp_c = sat24(asr64(sext(64'(fine_t), 32) * 64'd5 + 64'd128, 8));
            r.temp_ok = 1'b1;
        end
        fine = sext(64'(fine_t), 32);

        v1 = fine - 64'd128000;
        v2 = v1 * v1 * sext(cal_phi >> 16, 16);
        v2 = v2 + ((v1 * sext(cal_phi, 16)) << 17);
        v2 = v2 + (sext(cal_plo >> 48, 16) << 35);
        v1 = asr64(v1 * v1 * sext(cal_plo >> 32, 16), 8) +
             ((v1 * sext(cal_plo >> 16, 16)) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * (cal_plo & 64'hFFFF), 33);

        // zero divisor leaves pressure and humidity invalid
        if (v1 != 64'd0) begin
            p = 64'd1048576 - (64'(rp) >> 4);
            p = div_toward_zero(((p << 31) - v2) * 64'd3125, v1);
            a = asr64(sext(cal_p9, 16) * asr64(p, 13) * asr64(p, 13), 25);
            b = asr64(sext(cal_phi >> 48, 16) * p, 19);
            p = asr64(p + a + b, 8) + (sext(cal_phi >> 32, 16) << 4);
            r.press = sat24(div_toward_zero(p, 64'd256));
            r.press_ok = 1'b1;

            if (rh != HUM_OFF) begin
                h1 = 32'(cal_hum & 64'hFF);
                h2 = 32'(sext(cal_hum >> 8, 16));
                h3 = 32'((cal_hum >> 24) & 64'hFF);
                h4 = 32'(sext(cal_hum >> 32, 12));
                h5 = 32'(sext(cal_hum >> 44, 12));
                h6 = 32'(sext(cal_hum >> 56, 8));
                v = fine_t - 32'd76800;
                x = asr32((32'(rh) << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
                y = asr32((asr32(asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768), 10)
                           + 32'd2097152) * h2 + 32'd8192, 14);
                v = x * y;
                q = asr32(v, 15);
                v = v - asr32(asr32(q * q, 7) * h1, 4);
                // negative clamps to zero, top clamps to 100 %RH
                if (v[31]) v = 32'd0;
                else if (v > 32'd419430400) v = 32'd419430400;
                r.hum = 17'(v >> 12);
                r.hum_ok = 1'b1;
            end
        end
        return r;
    endfunction

    // expectation on input acceptance, check on output acceptance
    always @(posedge aclk) begin
        reading_t got, want, pred;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[23:0], m_tdata[24], m_tdata[48:25], m_tdata[49],
                   m_tdata[66:50], m_tdata[67]};
            if (readings_due.size() == 0) begin
                $error("result transaction with nothing expected: %h", m_tdata);
                errors++;
            end else begin
                want = readings_due.pop_front();
                if (got.temp_c !== want.temp_c) begin
                    $error("temperature_centi: expected %h, got %h", want.temp_c, got.temp_c);
                    errors++;
                end
                if (got.temp_ok !== want.temp_ok) begin
                    $error("temperature_valid: expected %b, got %b", want.temp_ok, got.temp_ok);
                    errors++;
                end
                if (got.press !== want.press) begin
                    $error("pressure_pa: expected %h, got %h", want.press, got.press);
                    errors++;
                end
                if (got.press_ok !== want.press_ok) begin
                    $error("pressure_valid: expected %b, got %b", want.press_ok, got.press_ok);
                    errors++;
                end
                if (got.hum !== want.hum) begin
                    $error("humidity_q10: expected %h, got %h", want.hum, got.hum);
                    errors++;
                end
                if (got.hum_ok !== want.hum_ok) begin
                    $error("humidity_valid: expected %b, got %b", want.hum_ok, got.hum_ok);
                    errors++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            pred = compensate(s_tdata[23:0], s_tdata[47:24], s_tdata[63:48]);
            // table rows with a typed-in value use it in place of the prediction
            if (typed_known.pop_front()) pred = typed_value.pop_front();
            else void'(typed_value.pop_front());
            readings_due.push_back(pred);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: stall pattern is redrawn at random from four modes; long hold-off on request
    initial begin
        int mode;
        int k;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                for (k = 0; k < 3000; k++) @(negedge aclk);
                long_hold = 1'b0;
            end
            if (cycles % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (cycles % 5 != 0);
            endcase
        end
    end

    task automatic apb_write(int idx, logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(idx * 8);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TEMP_CAL: cal_temp = val & 64'hFFFF_FFFF_FFFF;
            REG_PRESS_LO: cal_plo  = val;
            REG_PRESS_HI: cal_phi  = val;
            REG_PRESS_P9: cal_p9   = val & 64'hFFFF;
            REG_HUM_CAL:  cal_hum  = val;
            default: ;
        endcase
    endtask

    // stop offering, wait for every expected result, then write all calibration registers
    task automatic load_cal(logic [63:0] t, logic [63:0] lo, logic [63:0] hi,
                            logic [63:0] p9, logic [63:0] hum);
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0 || typed_known.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        apb_write(REG_TEMP_CAL, t);
        apb_write(REG_PRESS_LO, lo);
        apb_write(REG_PRESS_HI, hi);
        apb_write(REG_PRESS_P9, p9);
        apb_write(REG_HUM_CAL, hum);
    endtask

    task automatic load_cal_set(int which);
        case (which)
            CAL_RESET: load_cal('0, '0, '0, '0, '0);
            // common datasheet-style factory values
            CAL_TYPICAL: load_cal({16'hFC18, 16'd26435, 16'd27504},
                                  {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                                  {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                                  64'd6000,
                                  {8'd30, 12'd50, 12'd324, 8'd0, 16'd362, 8'd75});
            default: load_cal('1, '1, '1, '1, '1);
        endcase
    endtask

    // sender: offer one transaction at a falling edge and hold it until the block accepts it
    task automatic offer(logic [23:0] rt, logic [23:0] rp, logic [15:0] rh,
                         bit known, reading_t r);
        typed_known.push_back(known);
        typed_value.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata  <= {rh, rp, rt};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic idle_for(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic reading_t rd(logic [23:0] tc, bit tv, logic [23:0] pp, bit pv,
                                    logic [16:0] hq, bit hv);
        return '{tc, tv, pp, pv, hq, hv};
    endfunction

    stim_row_t table_rows[$];
    int cur_cal;

    initial begin
        int i, j, burst, kind;
        logic [23:0] rt, rp;
        logic [15:0] rh;

        cal_temp = '0; cal_plo = '0; cal_phi = '0; cal_p9 = '0; cal_hum = '0;
        fine_t = '0;

        // reset values give a zero divisor; zero calibration gives zero temperature
        table_rows = '{
            '{CAL_RESET, 24'h000000, 24'h000000, 16'h0000, 1, rd(0, 1, 0, 0, 0, 0)},
            '{CAL_RESET, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1, rd(0, 1, 0, 0, 0, 0)},
            '{CAL_RESET, SKIP_TEMP,  24'h555555, HUM_OFF,  1, rd(0, 0, 0, 0, 0, 0)},
            '{CAL_RESET, 24'h7FFFFF, 24'hAAAAAA, 16'h7FFF, 1, rd(0, 1, 0, 0, 0, 0)},
            '{CAL_TYPICAL, 24'h7EF100, 24'h655AC0, 16'h6D60, 0, '0},
            '{CAL_TYPICAL, SKIP_TEMP,  24'h655AC0, 16'h6D60, 0, '0},
            '{CAL_TYPICAL, 24'h7EF100, 24'h655AC0, HUM_OFF,  0, '0},
            '{CAL_TYPICAL, 24'h000000, 24'h000000, 16'h0000, 0, '0},
            '{CAL_TYPICAL, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 0, '0},
            '{CAL_TYPICAL, 24'h7FFFFF, 24'h800000, 16'h7FFF, 0, '0},
            '{CAL_TYPICAL, SKIP_TEMP,  24'h000000, 16'hFFFF, 0, '0},
            '{CAL_TYPICAL, 24'h5A0000, 24'h300000, 16'h9000, 0, '0},
            '{CAL_TYPICAL, 24'hA50000, 24'h900000, 16'h3000, 0, '0},
            '{CAL_ONES, 24'h000000, 24'h000000, 16'h0000, 0, '0},
            '{CAL_ONES, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 0, '0},
            '{CAL_ONES, SKIP_TEMP,  24'h123456, 16'h8001, 0, '0},
            '{CAL_ONES, 24'h7EF100, 24'h655AC0, HUM_OFF,  0, '0}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part
        cur_cal = CAL_RESET;
        foreach (table_rows[n]) begin
            if (table_rows[n].cal != cur_cal) begin
                cur_cal = table_rows[n].cal;
                load_cal_set(cur_cal);
            end
            offer(table_rows[n].rt, table_rows[n].rp, table_rows[n].rh,
                  table_rows[n].known, table_rows[n].exp_r);
            idle_for($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0);
        end

        // random part: phases with different calibration
        i = 0;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: load_cal_set(CAL_TYPICAL);
                1: load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            64'($urandom), {$urandom, $urandom});
                2: load_cal_set(CAL_ONES);
                3: load_cal({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                            64'($urandom), {$urandom, $urandom});
                4: load_cal_set(CAL_RESET);
                default: load_cal_set(CAL_TYPICAL);
            endcase
            // receiver holds off long enough that the block stalls its input
            if (phase == 1) long_hold = 1'b1;
            j = 0;
            while (j < N_RANDOM / 6) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && j < N_RANDOM / 6; b++) begin
                    kind = $urandom_range(0, 19);
                    rt = 24'($urandom_range(24'h600000, 24'h9FFFFF));
                    rp = 24'($urandom_range(24'h400000, 24'h7FFFFF));
                    rh = 16'($urandom_range(16'h4000, 16'hA000));
                    if (kind < 6) begin
                        rt = 24'($urandom); rp = 24'($urandom); rh = 16'($urandom);
                    end
                    if (kind == 6 || kind == 7) rt = SKIP_TEMP;
                    if (kind == 8) rh = HUM_OFF;
                    offer(rt, rp, rh, 0, '0);
                    j++;
                    i++;
                end
                idle_for($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300));
            end
        end

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ env_sensor_compensation.f @@
+incdir+hw/rtl
hw/rtl/esc_pkg.sv
hw/rtl/esc_mul.sv
hw/rtl/esc_div.sv
hw/rtl/esc_datapath.sv
hw/rtl/esc_ctrl.sv
hw/rtl/env_sensor_compensation.sv
hw/rtl/esc_checker.sv
verif/tb.sv
